@@ sv/eac_pkg.sv @@
// ----------------------------------------------------------------------------
// eac_pkg: shared types and constants of the extent allocator
// Command and status codes, sequencer states, table write operations.
// ----------------------------------------------------------------------------
package eac_pkg;

  localparam int unsigned STORE_BYTES_DEF = 4096;
  localparam int unsigned MAX_EXTENTS_DEF = 32;

  typedef enum logic [2:0] {
    CMD_ALLOC   = 3'd0,
    CMD_FREE    = 3'd1,
    CMD_WRITE   = 3'd2,
    CMD_READ    = 3'd3,
    CMD_COMPACT = 3'd4,
    CMD_LOOKUP  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_SPACE  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_TBL_FULL  = 3'd3,
    ST_BAD_ADDR  = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCANEND,
    S_RD,
    S_RDCAP,
    S_CINIT,
    S_CSCAN,
    S_CSEL,
    S_CMOVE,
    S_CDONE,
    S_ACOMMIT,
    S_RESP
  } state_t;

  // table write operation: set a new entry, clear valid, or move start
  typedef struct packed {
    logic set;
    logic clr;
    logic mv;
  } tbl_op_t;

endpackage

@@ sv/eac_if.sv @@
// ----------------------------------------------------------------------------
// eac_if: command and result channels
// Valid/ready channels carrying one command word or one result word.
// ----------------------------------------------------------------------------
interface eac_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [7:0]  file_id;
  logic [11:0] length;
  logic [11:0] address;
  logic        use_given_start;
  logic [7:0]  wdata;

  modport source (output valid, cmd, file_id, length, address, use_given_start, wdata,
                  input ready);
  modport sink (input valid, cmd, file_id, length, address, use_given_start, wdata,
                output ready);
endinterface

interface eac_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [11:0] extent_start;
  logic [11:0] extent_length;
  logic [7:0]  rdata;
  logic [11:0] used_top;

  modport source (output valid, status, extent_start, extent_length, rdata, used_top,
                  input ready);
  modport sink (input valid, status, extent_start, extent_length, rdata, used_top,
                output ready);
endinterface

@@ sv/extent_allocator_with_compaction_unit.sv @@
// ----------------------------------------------------------------------------
// extent_allocator_with_compaction_unit: extent allocator with compaction
// Sequencer over an extent table, a byte store and a bump pointer.
// ----------------------------------------------------------------------------
//  channel | dir | handshake         | word
//  in_chan | in  | valid/ready       | cmd, file_id, length, address,
//          |     |                   | use_given_start, wdata
//  out_chan| out | valid/ready       | status, extent_start, extent_length,
//          |     |                   | rdata, used_top
//
//  Unused codes go straight to the result; write and read use the store,
//  free/lookup/alloc scan every table entry.
//  Compaction of n valid extents: an init step, n + 1 table scans, a byte
//  copy per moved extent through the store, then the pointer set; an alloc
//  that compacts then retries in a commit step. Reset (rst_n low,
//  synchronous) clears the valid bits and the pointer. in_chan.ready is
//  high only while idle; a waiting result holds the block.
// ----------------------------------------------------------------------------
module extent_allocator_with_compaction_unit #(
  parameter int unsigned STORE_BYTES = eac_pkg::STORE_BYTES_DEF,
  parameter int unsigned MAX_EXTENTS = eac_pkg::MAX_EXTENTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  eac_in_if.sink     in_chan,
  eac_out_if.source  out_chan
);

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned IW = $clog2(MAX_EXTENTS);
  localparam int unsigned CW = ((AW > 12) ? AW : 12) + 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_EXTENTS - 1);
  localparam logic [CW-1:0] STORE_LIM = CW'(STORE_BYTES);

  eac_pkg::state_t st_r, st_nxt;

  // latched command word
  logic [2:0]  cmd_r, cmd_nxt;
  logic [7:0]  fid_r, fid_nxt;
  logic [11:0] len_r, len_nxt;
  logic [11:0] addr_r, addr_nxt;
  logic        given_r, given_nxt;
  logic [7:0]  wdata_r, wdata_nxt;

  // scan and allocation state
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] slot_r, slot_nxt;
  logic          found_r, found_nxt;
  logic          retry_r, retry_nxt;
  logic [AW-1:0] bump_r, bump_nxt;

  // result under construction
  logic [2:0]  res_status_r, res_status_nxt;
  logic [11:0] res_start_r, res_start_nxt;
  logic [11:0] res_len_r, res_len_nxt;
  logic [7:0]  res_rdata_r, res_rdata_nxt;

  // compaction state
  logic [AW-1:0]          end_r, end_nxt;
  logic [MAX_EXTENTS-1:0] visited_r, visited_nxt;
  logic [IW-1:0]          best_r, best_nxt;
  logic [AW-1:0]          best_st_r, best_st_nxt;
  logic [11:0]            best_len_r, best_len_nxt;
  logic                   bf_r, bf_nxt;
  logic [AW-1:0]          src_r, src_nxt;
  logic [AW-1:0]          dst_r, dst_nxt;
  logic [11:0]            rem_r, rem_nxt;
  logic                   pend_r, pend_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  out_status_r, out_status_nxt;
  logic [11:0] out_start_r, out_start_nxt;
  logic [11:0] out_len_r, out_len_nxt;
  logic [7:0]  out_rdata_r, out_rdata_nxt;
  logic [11:0] out_top_r, out_top_nxt;

  // table and store ports
  logic             t_valid;
  logic [7:0]       t_ident;
  logic [AW-1:0]    t_start;
  logic [11:0]      t_length;
  logic [IW-1:0]    t_rd_idx;
  eac_pkg::tbl_op_t t_op;
  logic [IW-1:0]    t_wr_idx;
  logic [AW-1:0]    t_wr_start;

  logic          m_we, m_re;
  logic [AW-1:0] m_waddr, m_raddr;
  logic [7:0]    m_wdata, m_rdata;

  // shared add/compare: candidate start plus length against the store size
  logic [CW-1:0] s_cur;
  logic [CW-1:0] s_sum;
  logic          s_fits;
  logic          addr_ok;

  assign s_cur   = (given_r && !retry_r) ? CW'(addr_r) : CW'(bump_r);
  assign s_sum   = s_cur + CW'(len_r);
  assign s_fits  = s_sum < STORE_LIM;
  assign addr_ok = CW'(addr_r) < STORE_LIM;

  eac_table #(.DEPTH(MAX_EXTENTS), .AW(AW), .IW(IW)) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_idx    (t_rd_idx),
    .rd_valid  (t_valid),
    .rd_ident  (t_ident),
    .rd_start  (t_start),
    .rd_length (t_length),
    .wr_op     (t_op),
    .wr_idx    (t_wr_idx),
    .wr_ident  (fid_r),
    .wr_start  (t_wr_start),
    .wr_length (len_r)
  );

  eac_byte_ram #(.DEPTH(STORE_BYTES), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .re    (m_re),
    .raddr (m_raddr),
    .rdata (m_rdata)
  );

  assign in_chan.ready          = (st_r == eac_pkg::S_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.status        = out_status_r;
  assign out_chan.extent_start  = out_start_r;
  assign out_chan.extent_length = out_len_r;
  assign out_chan.rdata         = out_rdata_r;
  assign out_chan.used_top      = out_top_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= eac_pkg::S_IDLE;
      bump_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      bump_r      <= bump_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r        <= cmd_nxt;
    fid_r        <= fid_nxt;
    len_r        <= len_nxt;
    addr_r       <= addr_nxt;
    given_r      <= given_nxt;
    wdata_r      <= wdata_nxt;
    idx_r        <= idx_nxt;
    slot_r       <= slot_nxt;
    found_r      <= found_nxt;
    retry_r      <= retry_nxt;
    res_status_r <= res_status_nxt;
    res_start_r  <= res_start_nxt;
    res_len_r    <= res_len_nxt;
    res_rdata_r  <= res_rdata_nxt;
    end_r        <= end_nxt;
    visited_r    <= visited_nxt;
    best_r       <= best_nxt;
    best_st_r    <= best_st_nxt;
    best_len_r   <= best_len_nxt;
    bf_r         <= bf_nxt;
    src_r        <= src_nxt;
    dst_r        <= dst_nxt;
    rem_r        <= rem_nxt;
    pend_r       <= pend_nxt;
    out_status_r <= out_status_nxt;
    out_start_r  <= out_start_nxt;
    out_len_r    <= out_len_nxt;
    out_rdata_r  <= out_rdata_nxt;
    out_top_r    <= out_top_nxt;
  end

  always_comb begin
    st_nxt         = st_r;
    cmd_nxt        = cmd_r;
    fid_nxt        = fid_r;
    len_nxt        = len_r;
    addr_nxt       = addr_r;
    given_nxt      = given_r;
    wdata_nxt      = wdata_r;
    idx_nxt        = idx_r;
    slot_nxt       = slot_r;
    found_nxt      = found_r;
    retry_nxt      = retry_r;
    bump_nxt       = bump_r;
    res_status_nxt = res_status_r;
    res_start_nxt  = res_start_r;
    res_len_nxt    = res_len_r;
    res_rdata_nxt  = res_rdata_r;
    end_nxt        = end_r;
    visited_nxt    = visited_r;
    best_nxt       = best_r;
    best_st_nxt    = best_st_r;
    best_len_nxt   = best_len_r;
    bf_nxt         = bf_r;
    src_nxt        = src_r;
    dst_nxt        = dst_r;
    rem_nxt        = rem_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_start_nxt  = out_start_r;
    out_len_nxt    = out_len_r;
    out_rdata_nxt  = out_rdata_r;
    out_top_nxt    = out_top_r;

    t_rd_idx   = idx_r;
    t_op       = '0;
    t_wr_idx   = idx_r;
    t_wr_start = AW'(s_cur);
    m_we       = 1'b0;
    m_waddr    = AW'(addr_r);
    m_wdata    = wdata_r;
    m_re       = 1'b0;
    m_raddr    = AW'(addr_r);

    // drop the result word once the sink takes it
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (st_r)
      eac_pkg::S_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt        = in_chan.cmd;
          fid_nxt        = in_chan.file_id;
          len_nxt        = in_chan.length;
          addr_nxt       = in_chan.address;
          given_nxt      = in_chan.use_given_start;
          wdata_nxt      = in_chan.wdata;
          idx_nxt        = '0;
          found_nxt      = 1'b0;
          retry_nxt      = 1'b0;
          res_status_nxt = eac_pkg::ST_OK;
          res_start_nxt  = '0;
          res_len_nxt    = '0;
          res_rdata_nxt  = '0;
          case (in_chan.cmd)
            eac_pkg::CMD_ALLOC,
            eac_pkg::CMD_FREE,
            eac_pkg::CMD_LOOKUP:  st_nxt = eac_pkg::S_SCAN;
            eac_pkg::CMD_WRITE,
            eac_pkg::CMD_READ:    st_nxt = eac_pkg::S_RD;
            eac_pkg::CMD_COMPACT: st_nxt = eac_pkg::S_CINIT;
            default:              st_nxt = eac_pkg::S_RESP;
          endcase
        end
      end

      // one table entry a cycle
      eac_pkg::S_SCAN: begin
        case (cmd_r)
          eac_pkg::CMD_ALLOC: begin
            if (!found_r && !t_valid) begin
              found_nxt = 1'b1;
              slot_nxt  = idx_r;
            end
          end
          eac_pkg::CMD_FREE: begin
            if (t_valid && t_ident == fid_r) begin
              t_op.clr  = 1'b1;
              found_nxt = 1'b1;
            end
          end
          default: begin
            if (!found_r && t_valid && t_ident == fid_r) begin
              found_nxt     = 1'b1;
              res_start_nxt = 12'(t_start);
              res_len_nxt   = t_length;
            end
          end
        endcase
        if (idx_r == LAST_IDX) begin
          st_nxt = eac_pkg::S_SCANEND;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      eac_pkg::S_SCANEND: begin
        st_nxt = eac_pkg::S_RESP;
        if (cmd_r == eac_pkg::CMD_ALLOC) begin
          if (!found_r) begin
            res_status_nxt = eac_pkg::ST_TBL_FULL;
          end else if (s_fits) begin
            t_op.set      = 1'b1;
            t_wr_idx      = slot_r;
            bump_nxt      = AW'(s_sum);
            res_start_nxt = 12'(s_cur);
          end else begin
            // compact, then retry at the new pointer
            retry_nxt = 1'b1;
            st_nxt    = eac_pkg::S_CINIT;
          end
        end else if (!found_r) begin
          res_status_nxt = eac_pkg::ST_NOT_FOUND;
        end
      end

      eac_pkg::S_RD: begin
        st_nxt = eac_pkg::S_RESP;
        if (!addr_ok) begin
          res_status_nxt = eac_pkg::ST_BAD_ADDR;
        end else if (cmd_r == eac_pkg::CMD_WRITE) begin
          m_we = 1'b1;
        end else begin
          m_re   = 1'b1;
          st_nxt = eac_pkg::S_RDCAP;
        end
      end

      eac_pkg::S_RDCAP: begin
        res_rdata_nxt = m_rdata;
        st_nxt        = eac_pkg::S_RESP;
      end

      eac_pkg::S_CINIT: begin
        visited_nxt = '0;
        end_nxt     = '0;
        idx_nxt     = '0;
        bf_nxt      = 1'b0;
        st_nxt      = eac_pkg::S_CSCAN;
      end

      // find the unvisited extent with the lowest start, earliest slot on ties
      eac_pkg::S_CSCAN: begin
        if (t_valid && !visited_r[idx_r] && (!bf_r || t_start < best_st_r)) begin
          bf_nxt       = 1'b1;
          best_nxt     = idx_r;
          best_st_nxt  = t_start;
          best_len_nxt = t_length;
        end
        if (idx_r == LAST_IDX) begin
          st_nxt = eac_pkg::S_CSEL;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      eac_pkg::S_CSEL: begin
        idx_nxt = '0;
        bf_nxt  = 1'b0;
        if (!bf_r) begin
          st_nxt = eac_pkg::S_CDONE;
        end else begin
          visited_nxt[best_r] = 1'b1;
          if (best_st_r > end_r) begin
            // slide down to close the gap, then move the bytes
            t_op.mv    = 1'b1;
            t_wr_idx   = best_r;
            t_wr_start = end_r;
            src_nxt    = best_st_r;
            dst_nxt    = end_r;
            rem_nxt    = best_len_r;
            pend_nxt   = 1'b0;
            end_nxt    = AW'(CW'(end_r) + CW'(best_len_r));
            st_nxt     = eac_pkg::S_CMOVE;
          end else begin
            end_nxt = AW'(CW'(best_st_r) + CW'(best_len_r));
            st_nxt  = eac_pkg::S_CSCAN;
          end
        end
      end

      // read one byte ahead, write the byte read in the cycle before
      eac_pkg::S_CMOVE: begin
        m_raddr = src_r;
        m_waddr = dst_r;
        m_wdata = m_rdata;
        if (pend_r) begin
          m_we    = 1'b1;
          dst_nxt = dst_r + 1'b1;
        end
        if (rem_r != '0) begin
          m_re     = 1'b1;
          src_nxt  = src_r + 1'b1;
          rem_nxt  = rem_r - 1'b1;
          pend_nxt = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            st_nxt = eac_pkg::S_CSCAN;
          end
        end
      end

      eac_pkg::S_CDONE: begin
        bump_nxt = end_r;
        st_nxt   = retry_r ? eac_pkg::S_ACOMMIT : eac_pkg::S_RESP;
      end

      eac_pkg::S_ACOMMIT: begin
        st_nxt = eac_pkg::S_RESP;
        if (s_fits) begin
          t_op.set      = 1'b1;
          t_wr_idx      = slot_r;
          bump_nxt      = AW'(s_sum);
          res_start_nxt = 12'(s_cur);
        end else begin
          res_status_nxt = eac_pkg::ST_NO_SPACE;
        end
      end

      // hold until the output register is free
      eac_pkg::S_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_start_nxt  = res_start_r;
          out_len_nxt    = res_len_r;
          out_rdata_nxt  = res_rdata_r;
          out_top_nxt    = 12'(bump_r);
          st_nxt         = eac_pkg::S_IDLE;
        end
      end

      default: st_nxt = eac_pkg::S_IDLE;
    endcase
  end

endmodule

@@ sv/eac_byte_ram.sv @@
// ----------------------------------------------------------------------------
// eac_byte_ram: byte store
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module eac_byte_ram #(
  parameter int unsigned DEPTH = eac_pkg::STORE_BYTES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ sv/eac_table.sv @@
// ----------------------------------------------------------------------------
// eac_table: extent table
// Valid bits, identifiers, starts and lengths; one read index, one write.
// ----------------------------------------------------------------------------
module eac_table #(
  parameter int unsigned DEPTH = eac_pkg::MAX_EXTENTS_DEF,
  parameter int unsigned AW    = 12,
  parameter int unsigned IW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [IW-1:0]   rd_idx,
  output logic            rd_valid,
  output logic [7:0]      rd_ident,
  output logic [AW-1:0]   rd_start,
  output logic [11:0]     rd_length,
  input  eac_pkg::tbl_op_t wr_op,
  input  logic [IW-1:0]   wr_idx,
  input  logic [7:0]      wr_ident,
  input  logic [AW-1:0]   wr_start,
  input  logic [11:0]     wr_length
);

  logic [DEPTH-1:0] valid_r;
  logic [7:0]       ident_r  [DEPTH];
  logic [AW-1:0]    start_r  [DEPTH];
  logic [11:0]      length_r [DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_op.set) begin
      valid_r[wr_idx] <= 1'b1;
    end else if (wr_op.clr) begin
      valid_r[wr_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_op.set) begin
      ident_r[wr_idx]  <= wr_ident;
      length_r[wr_idx] <= wr_length;
    end
    if (wr_op.set || wr_op.mv) begin
      start_r[wr_idx] <= wr_start;
    end
  end

  assign rd_valid  = valid_r[rd_idx];
  assign rd_ident  = ident_r[rd_idx];
  assign rd_start  = start_r[rd_idx];
  assign rd_length = length_r[rd_idx];

endmodule

@@ tb/eac_tb_pkg.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// eac_tb_pkg: extent allocator scoreboard
// Keeps a shadow of the extent table, byte store and pointer and checks each
// result word against the one predicted from the accepted command.
// ----------------------------------------------------------------------------
package eac_tb_pkg;

  localparam int unsigned NBYTES = eac_pkg::STORE_BYTES_DEF;
  localparam int unsigned NEXT   = eac_pkg::MAX_EXTENTS_DEF;

  typedef struct {
    logic [2:0]  status;
    logic [11:0] xstart;
    logic [11:0] xlen;
    logic [7:0]  rdata;
    logic [11:0] top;
  } alloc_result_t;

  class extent_scoreboard;
    bit          ent_valid [NEXT];
    bit [7:0]    ent_id    [NEXT];
    int unsigned ent_start [NEXT];
    int unsigned ent_len   [NEXT];
    bit [7:0]    bytes     [NBYTES];
    bit          written   [NBYTES];
    int unsigned top;
    alloc_result_t pending[$];
    int errors;

    function new();
      top = 0;
      errors = 0;
      foreach (ent_valid[i]) ent_valid[i] = 0;
      foreach (bytes[i]) begin
        bytes[i] = 0;
        written[i] = 0;
      end
    endfunction

    // slide valid extents down in start order, equal starts in table order
    function void compact();
      int unsigned ord[$];
      int unsigned fill, s, e;
      int j;
      fill = 0;
      for (int i = 0; i < NEXT; i++) begin
        if (ent_valid[i]) begin
          j = ord.size();
          while (j > 0 && ent_start[ord[j-1]] > ent_start[i]) j--;
          ord.insert(j, i);
        end
      end
      foreach (ord[k]) begin
        e = ord[k];
        s = ent_start[e];
        if (s > fill) begin
          for (int b = 0; b < ent_len[e]; b++) begin
            if (s + b < NBYTES && fill + b < NBYTES) begin
              bytes[fill+b] = bytes[s+b];
              written[fill+b] = written[s+b];
            end
          end
          ent_start[e] = fill;
          s = fill;
        end
        fill = s + ent_len[e];
      end
      top = fill;
    endfunction

    function void note_command(logic [2:0] cmd, logic [7:0] id, logic [11:0] len,
                               logic [11:0] addr, logic given, logic [7:0] wd);
      alloc_result_t r;
      int slot;
      int unsigned s;
      bit found;
      r = '{eac_pkg::ST_OK, 12'd0, 12'd0, 8'd0, 12'd0};
      case (cmd)
        eac_pkg::CMD_ALLOC: begin
          slot = -1;
          for (int i = 0; i < NEXT; i++)
            if (!ent_valid[i] && slot < 0) slot = i;
          if (slot < 0) begin
            r.status = eac_pkg::ST_TBL_FULL;
          end else begin
            s = given ? 32'(addr) : top;
            if (s + 32'(len) >= NBYTES) begin
              compact();
              s = top;
            end
            if (s + 32'(len) < NBYTES) begin
              ent_valid[slot] = 1;
              ent_id[slot] = id;
              ent_start[slot] = s;
              ent_len[slot] = 32'(len);
              top = s + 32'(len);
              r.xstart = 12'(s);
            end else begin
              r.status = eac_pkg::ST_NO_SPACE;
            end
          end
        end
        eac_pkg::CMD_FREE: begin
          found = 0;
          for (int i = 0; i < NEXT; i++)
            if (ent_valid[i] && ent_id[i] == id) begin
              ent_valid[i] = 0;
              found = 1;
            end
          if (!found) r.status = eac_pkg::ST_NOT_FOUND;
        end
        eac_pkg::CMD_WRITE: begin
          if (32'(addr) >= NBYTES) r.status = eac_pkg::ST_BAD_ADDR;
          else begin
            bytes[addr] = wd;
            written[addr] = 1;
          end
        end
        eac_pkg::CMD_READ: begin
          if (32'(addr) >= NBYTES) r.status = eac_pkg::ST_BAD_ADDR;
          else r.rdata = bytes[addr];
        end
        eac_pkg::CMD_COMPACT: compact();
        eac_pkg::CMD_LOOKUP: begin
          r.status = eac_pkg::ST_NOT_FOUND;
          for (int i = NEXT - 1; i >= 0; i--)
            if (ent_valid[i] && ent_id[i] == id) begin
              r.status = eac_pkg::ST_OK;
              r.xstart = 12'(ent_start[i]);
              r.xlen = 12'(ent_len[i]);
            end
        end
        default: ;
      endcase
      r.top = top[11:0];
      pending = {pending, r};
    endfunction

    function void check_result(logic [2:0] st, logic [11:0] xs, logic [11:0] xl,
                               logic [7:0] rd, logic [11:0] tp);
      alloc_result_t r;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      r = pending.pop_front();
      if (st !== r.status) begin
        $error("status exp %0d got %0d", r.status, st);
        errors++;
      end
      if (xs !== r.xstart) begin
        $error("extent_start exp %0d got %0d", r.xstart, xs);
        errors++;
      end
      if (xl !== r.xlen) begin
        $error("extent_length exp %0d got %0d", r.xlen, xl);
        errors++;
      end
      if (rd !== r.rdata) begin
        $error("rdata exp %0d got %0d", r.rdata, rd);
        errors++;
      end
      if (tp !== r.top) begin
        $error("used_top exp %0d got %0d", r.top, tp);
        errors++;
      end
    endfunction
  endclass
endpackage

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: extent allocator testbench
// Directed corner commands, then mostly alloc/write/read/free sequences with
// random content, checked word by word against the scoreboard's shadow state.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] CMD_SPARE_A = 3'd6;
  localparam logic [2:0] CMD_SPARE_B = 3'd7;

  logic clk = 0;
  logic rst_n = 0;
  eac_in_if  in_chan();
  eac_out_if out_chan();

  extent_allocator_with_compaction_unit dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan.sink), .out_chan(out_chan.source)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  eac_tb_pkg::extent_scoreboard board = new();
  bit hold_off = 0;
  int idle_cycles = 0;
  // worst compaction: 33 scans of the table plus about 4096 byte moves
  localparam int WATCHDOG = 40000;

  // drive one command word and wait for its acceptance; valid stays high
  task automatic send_word(logic [2:0] cmd, logic [7:0] id, logic [11:0] len,
                           logic [11:0] addr, logic given, logic [7:0] wd);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap != 0) begin
      in_chan.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1;
    in_chan.cmd <= cmd;
    in_chan.file_id <= id;
    in_chan.length <= len;
    in_chan.address <= addr;
    in_chan.use_given_start <= given;
    in_chan.wdata <= wd;
    do @(posedge clk); while (!in_chan.ready);
    board.note_command(cmd, id, len, addr, given, wd);
  endtask

  // find a written byte, starting the search at a random place
  function automatic bit find_written(output logic [11:0] a);
    int start;
    start = $urandom_range(0, eac_tb_pkg::NBYTES - 1);
    a = 12'd0;
    for (int t = 0; t < eac_tb_pkg::NBYTES; t++) begin
      int p;
      p = (start + t) % eac_tb_pkg::NBYTES;
      if (board.written[p]) begin
        a = 12'(p);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // read a written byte, or write a random one when none is known
  task automatic read_known(logic [7:0] id);
    logic [11:0] a;
    if (find_written(a)) begin
      send_word(eac_pkg::CMD_READ, id, 12'($urandom), a, 1'($urandom), 8'($urandom));
    end else begin
      send_word(eac_pkg::CMD_WRITE, id, 12'd0, 12'($urandom_range(0, 4095)), 1'b0,
                8'($urandom_range(0, 255)));
    end
  endtask

  task automatic drain();
    in_chan.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    int gap;
    out_chan.ready = 0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_chan.ready <= 0;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_chan.ready <= 0;
        repeat (gap) @(posedge clk);
      end
      out_chan.ready <= 1;
      do @(posedge clk); while (!out_chan.valid);
      board.check_result(out_chan.status, out_chan.extent_start,
                         out_chan.extent_length, out_chan.rdata, out_chan.used_top);
    end
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    int pick, n;
    logic [7:0] id;
    in_chan.valid = 0;
    in_chan.cmd = eac_pkg::CMD_ALLOC;
    in_chan.file_id = 0;
    in_chan.length = 0;
    in_chan.address = 0;
    in_chan.use_given_start = 0;
    in_chan.wdata = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corners: empty table, extremes, every code
    send_word(eac_pkg::CMD_COMPACT, 8'h00, 12'd0, 12'd0, 1'b0, 8'h00);
    send_word(eac_pkg::CMD_LOOKUP, 8'hFF, 12'd0, 12'd0, 1'b0, 8'h00);
    send_word(eac_pkg::CMD_FREE, 8'h00, 12'd0, 12'd0, 1'b0, 8'h00);
    send_word(eac_pkg::CMD_ALLOC, 8'hFF, 12'd0, 12'd0, 1'b0, 8'h00);
    send_word(eac_pkg::CMD_ALLOC, 8'h01, 12'd4095, 12'd0, 1'b0, 8'h00);
    send_word(eac_pkg::CMD_ALLOC, 8'h02, 12'd100, 12'd4000, 1'b1, 8'h00);
    send_word(eac_pkg::CMD_ALLOC, 8'h02, 12'd16, 12'd4095, 1'b1, 8'h00);
    send_word(eac_pkg::CMD_WRITE, 8'h00, 12'd0, 12'd4095, 1'b0, 8'hFF);
    send_word(eac_pkg::CMD_WRITE, 8'h00, 12'd0, 12'd4008, 1'b0, 8'hA5);
    send_word(eac_pkg::CMD_READ, 8'h00, 12'd0, 12'd4095, 1'b0, 8'h00);
    send_word(eac_pkg::CMD_ALLOC, 8'h03, 12'd50, 12'd4010, 1'b1, 8'h00);
    send_word(eac_pkg::CMD_ALLOC, 8'h04, 12'd20, 12'd4015, 1'b1, 8'h00);
    send_word(eac_pkg::CMD_LOOKUP, 8'h02, 12'd0, 12'd0, 1'b0, 8'h00);
    send_word(eac_pkg::CMD_COMPACT, 8'h00, 12'd0, 12'd0, 1'b0, 8'h00);
    read_known(8'h00);
    send_word(eac_pkg::CMD_FREE, 8'h02, 12'd0, 12'd0, 1'b0, 8'h00);
    send_word(eac_pkg::CMD_ALLOC, 8'h05, 12'd4090, 12'd0, 1'b0, 8'h00);
    send_word(CMD_SPARE_A, 8'h55, 12'hAAA, 12'h555, 1'b1, 8'h5A);
    send_word(CMD_SPARE_B, 8'hAA, 12'h555, 12'hAAA, 1'b0, 8'hA5);
    // fill the table
    for (int i = 0; i < eac_tb_pkg::NEXT + 1; i++)
      send_word(eac_pkg::CMD_ALLOC, 8'h10, 12'd1, 12'd0, 1'b0, 8'h00);
    send_word(eac_pkg::CMD_FREE, 8'h10, 12'd0, 12'd0, 1'b0, 8'h00);
    drain();

    // random part: small extents, writes and reads on written bytes
    for (int k = 0; k < 700; k++) begin
      if (k == 300) begin
        hold_off = 1;  // receiver stalls long, the block backs up
      end
      if (k == 500) begin
        drain();       // sender pauses until all results are in
      end
      pick = $urandom_range(0, 99);
      id = 8'($urandom_range(0, 15));
      if (pick < 25) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 4095) : $urandom_range(0, 200);
        send_word(eac_pkg::CMD_ALLOC, id, 12'(n), 12'($urandom_range(0, 4095)),
                  1'($urandom_range(0, 1)), 8'h00);
      end else if (pick < 40) begin
        send_word(eac_pkg::CMD_FREE, id, 12'($urandom), 12'($urandom), 1'($urandom),
                  8'($urandom));
      end else if (pick < 60) begin
        send_word(eac_pkg::CMD_WRITE, id, 12'($urandom), 12'($urandom_range(0, 4095)),
                  1'($urandom), 8'($urandom_range(0, 255)));
      end else if (pick < 75) begin
        read_known(id);
      end else if (pick < 80) begin
        send_word(eac_pkg::CMD_COMPACT, id, 12'($urandom), 12'($urandom), 1'($urandom),
                  8'($urandom));
      end else if (pick < 95) begin
        send_word(eac_pkg::CMD_LOOKUP,
                  8'($urandom_range(0, 255) % ((pick & 1) ? 16 : 256)),
                  12'd0, 12'd0, 1'b0, 8'h00);
      end else begin
        send_word(($urandom_range(0, 1) == 0) ? CMD_SPARE_A : CMD_SPARE_B,
                  8'($urandom), 12'($urandom), 12'($urandom), 1'($urandom),
                  8'($urandom));
      end
    end

    drain();
    repeat (50) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
